// File: rtl/adc_scan_offset_calibrator_unit_assert.svh
// assertion macros for the adc scan offset calibrator
// depends on nothing; used by the top level only
`ifndef ADC_SCAN_OFFSET_CALIBRATOR_UNIT_ASSERT_SVH
`define ADC_SCAN_OFFSET_CALIBRATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define ASOC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASOC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/asoc_pkg.sv
// shared types, codes and microcode rom for the adc scan offset calibrator
// depends on nothing
package asoc_pkg;

  localparam int unsigned SLOTS        = 8;
  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned RAW_W        = 10;
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned NUM_W        = 18;
  localparam int unsigned DEN_W        = 9;
  localparam int unsigned STEP_W       = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  // item kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  // datapath operations
  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_SAMPLE    = 4'd1;
  localparam logic [3:0] OP_CLEAR     = 4'd2;
  localparam logic [3:0] OP_READ      = 4'd3;
  localparam logic [3:0] OP_MAX_INIT  = 4'd4;
  localparam logic [3:0] OP_MAX_STEP  = 4'd5;
  localparam logic [3:0] OP_IDX_CLR   = 4'd6;
  localparam logic [3:0] OP_MUL       = 4'd7;
  localparam logic [3:0] OP_DIV_START = 4'd8;
  localparam logic [3:0] OP_DIV_WAIT  = 4'd9;
  localparam logic [3:0] OP_WRITE_OFF = 4'd10;
  localparam logic [3:0] OP_CNT_INC   = 4'd11;

  // jump conditions
  localparam logic [1:0] JC_NONE   = 2'd0;
  localparam logic [1:0] JC_ALWAYS = 2'd1;
  localparam logic [1:0] JC_MORE   = 2'd2;
  localparam logic [1:0] JC_BUSY   = 2'd3;

  // microprogram addresses
  localparam logic [STEP_W-1:0] ST_SAMPLE    = 4'd0;
  localparam logic [STEP_W-1:0] ST_CLEAR     = 4'd1;
  localparam logic [STEP_W-1:0] ST_READ      = 4'd2;
  localparam logic [STEP_W-1:0] ST_MAX_INIT  = 4'd3;
  localparam logic [STEP_W-1:0] ST_MAX_STEP  = 4'd4;
  localparam logic [STEP_W-1:0] ST_IDX_CLR   = 4'd5;
  localparam logic [STEP_W-1:0] ST_MUL       = 4'd6;
  localparam logic [STEP_W-1:0] ST_DIV_START = 4'd7;
  localparam logic [STEP_W-1:0] ST_DIV_WAIT  = 4'd8;
  localparam logic [STEP_W-1:0] ST_WRITE_OFF = 4'd9;
  localparam logic [STEP_W-1:0] ST_CNT_INC   = 4'd10;

  typedef struct packed {
    logic [3:0]        op;
    logic [1:0]        jc;
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_t;

  typedef struct packed {
    logic more;
    logic div_busy;
  } seq_stat_t;

  function automatic ucode_t asoc_ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_NOP, jc: JC_NONE, target: ST_SAMPLE, last: 1'b1};
    case (step)
      ST_SAMPLE:    w = '{op: OP_SAMPLE,    jc: JC_NONE, target: ST_SAMPLE,    last: 1'b1};
      ST_CLEAR:     w = '{op: OP_CLEAR,     jc: JC_NONE, target: ST_SAMPLE,    last: 1'b1};
      ST_READ:      w = '{op: OP_READ,      jc: JC_NONE, target: ST_SAMPLE,    last: 1'b1};
      ST_MAX_INIT:  w = '{op: OP_MAX_INIT,  jc: JC_NONE, target: ST_SAMPLE,    last: 1'b0};
      ST_MAX_STEP:  w = '{op: OP_MAX_STEP,  jc: JC_MORE, target: ST_MAX_STEP,  last: 1'b0};
      ST_IDX_CLR:   w = '{op: OP_IDX_CLR,   jc: JC_NONE, target: ST_SAMPLE,    last: 1'b0};
      ST_MUL:       w = '{op: OP_MUL,       jc: JC_NONE, target: ST_SAMPLE,    last: 1'b0};
      ST_DIV_START: w = '{op: OP_DIV_START, jc: JC_NONE, target: ST_SAMPLE,    last: 1'b0};
      ST_DIV_WAIT:  w = '{op: OP_DIV_WAIT,  jc: JC_BUSY, target: ST_DIV_WAIT,  last: 1'b0};
      ST_WRITE_OFF: w = '{op: OP_WRITE_OFF, jc: JC_MORE, target: ST_MUL,       last: 1'b0};
      ST_CNT_INC:   w = '{op: OP_CNT_INC,   jc: JC_NONE, target: ST_SAMPLE,    last: 1'b1};
      default:      w = '{op: OP_NOP,       jc: JC_NONE, target: ST_SAMPLE,    last: 1'b1};
    endcase
    return w;
  endfunction

  function automatic logic [STEP_W-1:0] asoc_entry(input logic [1:0] kind);
    logic [STEP_W-1:0] s;
    s = ST_SAMPLE;
    unique case (kind)
      KIND_SAMPLE: s = ST_SAMPLE;
      KIND_UPDATE: s = ST_MAX_INIT;
      KIND_CLEAR:  s = ST_CLEAR;
      KIND_READ:   s = ST_READ;
      default:     s = ST_SAMPLE;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/asoc_div.sv
// shift-subtract divider, one quotient bit per cycle
// depends on asoc_pkg
module asoc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [asoc_pkg::NUM_W-1:0]    num,
  input  logic [asoc_pkg::DEN_W-1:0]    den,
  output logic                          busy,
  output logic [asoc_pkg::NUM_W-1:0]    quot
);

  localparam int unsigned CW = $clog2(asoc_pkg::NUM_W + 1);

  logic [asoc_pkg::NUM_W-1:0] num_r;
  logic [asoc_pkg::DEN_W-1:0] den_r;
  logic [asoc_pkg::DEN_W-1:0] rem_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r;
  logic [asoc_pkg::DEN_W:0]   trial;
  logic                       ge;

  // remainder stays below the divisor, so one extra bit covers the shifted value
  assign trial = {rem_r, num_r[asoc_pkg::NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(asoc_pkg::NUM_W);
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? asoc_pkg::DEN_W'(trial - {1'b0, den_r})
                   : trial[asoc_pkg::DEN_W-1:0];
      num_r  <= {num_r[asoc_pkg::NUM_W-2:0], ge};
      cnt_r  <= cnt_r - CW'(1);
      busy_r <= (cnt_r != CW'(1));
    end
  end

  assign busy = busy_r;
  assign quot = num_r;

endmodule

// File: rtl/asoc_seq.sv
// microcode sequencer: step counter, rom fetch and conditional jumps
// depends on asoc_pkg
module asoc_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           kind,
  input  asoc_pkg::seq_stat_t  stat,
  output asoc_pkg::ucode_t     ctl,
  output logic                 busy,
  output logic                 done
);

  logic [asoc_pkg::STEP_W-1:0] step_r;
  logic                        busy_r;
  asoc_pkg::ucode_t            word;
  logic                        taken;

  assign word = asoc_pkg::asoc_ucode(step_r);

  always_comb begin
    taken = 1'b0;
    unique case (word.jc)
      asoc_pkg::JC_NONE:   taken = 1'b0;
      asoc_pkg::JC_ALWAYS: taken = 1'b1;
      asoc_pkg::JC_MORE:   taken = stat.more;
      asoc_pkg::JC_BUSY:   taken = stat.div_busy;
      default:             taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= asoc_pkg::ST_SAMPLE;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= asoc_pkg::asoc_entry(kind);
    end else if (busy_r) begin
      if (taken) begin
        step_r <= word.target;
      end else if (word.last) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + asoc_pkg::STEP_W'(1);
      end
    end
  end

  always_comb begin
    ctl = word;
    if (!busy_r) begin
      ctl.op = asoc_pkg::OP_NOP;
    end
  end

  assign busy = busy_r;
  assign done = busy_r && word.last && !taken;

endmodule

// File: rtl/asoc_dp.sv
// datapath: raw and offset registers, scan pointer, max tracker, multiply-add
// depends on asoc_pkg; quotient comes from asoc_div
module asoc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  asoc_pkg::ucode_t              ctl,
  input  logic [3:0]                    channel_count,
  input  logic [asoc_pkg::RAW_W-1:0]    sample,
  input  logic [2:0]                    channel,
  input  logic [asoc_pkg::NUM_W-1:0]    quot,
  input  logic                          div_busy,
  output asoc_pkg::seq_stat_t           stat,
  output logic                          div_start,
  output logic [asoc_pkg::NUM_W-1:0]    div_num,
  output logic [asoc_pkg::DEN_W-1:0]    div_den,
  output logic [2:0]                    ptr,
  output logic [2:0]                    stored,
  output logic [15:0]                   value,
  output logic [asoc_pkg::CNT_W-1:0]    cal_count
);

  logic [asoc_pkg::RAW_W-1:0] raw_r [asoc_pkg::SLOTS];
  logic [asoc_pkg::RAW_W-1:0] off_r [asoc_pkg::SLOTS];
  logic [2:0]                 ptr_r;
  logic [2:0]                 idx_r;
  logic [asoc_pkg::RAW_W-1:0] top_r;
  logic [asoc_pkg::CNT_W-1:0] cnt_r;
  logic [asoc_pkg::NUM_W-1:0] num_r;
  logic [2:0]                 stored_r;
  logic [15:0]                value_r;

  logic [3:0]                 n_act;
  logic [2:0]                 target;
  logic [3:0]                 ptr_inc;
  logic [2:0]                 ptr_nxt;
  logic [2:0]                 rd_idx;
  logic [asoc_pkg::RAW_W-1:0] raw_rd;
  logic [asoc_pkg::RAW_W-1:0] off_rd;
  logic [asoc_pkg::RAW_W-1:0] fresh;
  logic [asoc_pkg::NUM_W-1:0] prod;

  // zero scans as one channel, anything above the limit as the limit
  always_comb begin
    if (channel_count == 4'd0) begin
      n_act = 4'd1;
    end else if (channel_count > 4'(asoc_pkg::MAX_CHANNELS)) begin
      n_act = 4'(asoc_pkg::MAX_CHANNELS);
    end else begin
      n_act = channel_count;
    end
  end

  assign target  = (ptr_r == 3'd0) ? 3'(n_act - 4'd1) : (ptr_r - 3'd1);
  assign ptr_inc = {1'b0, ptr_r} + 4'd1;
  assign ptr_nxt = (ptr_inc >= n_act) ? 3'd0 : ptr_inc[2:0];

  assign rd_idx = (ctl.op == asoc_pkg::OP_READ) ? channel : idx_r;
  assign raw_rd = raw_r[rd_idx];
  assign off_rd = off_r[rd_idx];
  assign fresh  = top_r - raw_rd;
  assign prod   = asoc_pkg::NUM_W'(off_rd) * asoc_pkg::NUM_W'(cnt_r)
                + asoc_pkg::NUM_W'(fresh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < asoc_pkg::SLOTS; i++) begin
        raw_r[i] <= '0;
        off_r[i] <= '0;
      end
      ptr_r    <= 3'd1;
      cnt_r    <= '0;
      idx_r    <= '0;
      top_r    <= '0;
      stored_r <= '0;
      value_r  <= '0;
    end else begin
      unique case (ctl.op)
        asoc_pkg::OP_SAMPLE: begin
          raw_r[target] <= sample;
          ptr_r         <= ptr_nxt;
          stored_r      <= target;
          value_r       <= '0;
        end
        asoc_pkg::OP_CLEAR: begin
          for (int i = 0; i < asoc_pkg::SLOTS; i++) begin
            off_r[i] <= '0;
          end
          cnt_r    <= '0;
          stored_r <= '0;
          value_r  <= '0;
        end
        asoc_pkg::OP_READ: begin
          stored_r <= channel;
          value_r  <= 16'({6'd0, raw_rd} - {6'd0, off_rd});
        end
        asoc_pkg::OP_MAX_INIT: begin
          top_r    <= '0;
          idx_r    <= '0;
          stored_r <= '0;
          value_r  <= '0;
        end
        asoc_pkg::OP_MAX_STEP: begin
          if (raw_rd > top_r) begin
            top_r <= raw_rd;
          end
          idx_r <= idx_r + 3'd1;
        end
        asoc_pkg::OP_IDX_CLR: begin
          idx_r <= '0;
        end
        asoc_pkg::OP_MUL: begin
          num_r <= prod;
        end
        asoc_pkg::OP_WRITE_OFF: begin
          off_r[idx_r] <= quot[asoc_pkg::RAW_W-1:0];
          idx_r        <= idx_r + 3'd1;
        end
        asoc_pkg::OP_CNT_INC: begin
          if (cnt_r != asoc_pkg::CNT_MAX) begin
            cnt_r <= cnt_r + asoc_pkg::CNT_W'(1);
          end
        end
        asoc_pkg::OP_NOP, asoc_pkg::OP_DIV_START, asoc_pkg::OP_DIV_WAIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.more     = (({1'b0, idx_r} + 4'd1) < n_act);
  assign stat.div_busy = div_busy;
  assign div_start     = (ctl.op == asoc_pkg::OP_DIV_START);
  assign div_num       = num_r;
  assign div_den       = {1'b0, cnt_r} + asoc_pkg::DEN_W'(1);
  assign ptr           = ptr_r;
  assign stored        = stored_r;
  assign value         = value_r;
  assign cal_count     = cnt_r;

endmodule

// File: rtl/adc_scan_offset_calibrator_unit.sv
// top level of the adc scan offset calibrator: stream ports, apb registers, output register
// depends on asoc_pkg, asoc_seq, asoc_dp, asoc_div and the assertion macro header
//
//  channel | direction | payload
//  in_     | slave     | tuser = kind; tdata = sample, channel
//  out_    | master    | tdata = next_mux, stored_channel, value, calibration_count
//  cfg_    | apb slave | 0x0 channel_count, 0x8 mux_codes
//
// sample, clear and read transactions end at their entry microcode word
// a calibrate update finds the largest raw value, then runs the shift-subtract divider
//   once per active channel
// reset is synchronous, active low; raw values and offsets clear, scan pointer goes to one
// a result held in the output register does not block the next item; each result first
//   waits in fin_r, which blocks input until the output register frees
`include "adc_scan_offset_calibrator_unit_assert.svh"

module adc_scan_offset_calibrator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample[9:0], channel[12:10], zero fill
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // next_mux[4:0], stored_channel[7:5], value[23:8],
                                  // calibration_count[31:24]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_MUX_CODES     = 1'b1;

  // configuration
  logic [3:0]  chan_cnt_r;
  logic [39:0] mux_codes_r;
  logic        cfg_wr;

  // latched input transaction
  logic [1:0]                    kind_r;
  logic [asoc_pkg::RAW_W-1:0]    sample_r;
  logic [2:0]                    channel_r;
  logic                          in_acc;

  // sequencer and datapath
  asoc_pkg::ucode_t              ctl;
  asoc_pkg::seq_stat_t           stat;
  logic                          seq_busy;
  logic                          seq_done;
  logic                          div_start;
  logic                          div_busy;
  logic [asoc_pkg::NUM_W-1:0]    div_num;
  logic [asoc_pkg::DEN_W-1:0]    div_den;
  logic [asoc_pkg::NUM_W-1:0]    div_quot;
  logic [2:0]                    ptr;
  logic [2:0]                    stored;
  logic [15:0]                   value;
  logic [asoc_pkg::CNT_W-1:0]    cal_count;

  // result staging
  logic        fin_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_free;
  logic [4:0]  next_mux;

  // apb: every write completes at once; address bit 3 picks the register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r  <= 4'd8;
      mux_codes_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3])
        REG_CHANNEL_COUNT: chan_cnt_r  <= cfg_pwdata[3:0];
        REG_MUX_CODES:     mux_codes_r <= cfg_pwdata[39:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[3])
      REG_CHANNEL_COUNT: cfg_prdata = 64'(chan_cnt_r);
      REG_MUX_CODES:     cfg_prdata = 64'(mux_codes_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // one item in flight; a finished result waits in fin_r until the output register frees
  assign in_tready = rst_n && !seq_busy && !fin_r;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r    <= in_tuser;
      sample_r  <= in_tdata[9:0];
      channel_r <= in_tdata[12:10];
    end
  end

  asoc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .kind  (in_tuser),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (seq_busy),
    .done  (seq_done)
  );

  asoc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .channel_count (chan_cnt_r),
    .sample        (sample_r),
    .channel       (channel_r),
    .quot          (div_quot),
    .div_busy      (div_busy),
    .stat          (stat),
    .div_start     (div_start),
    .div_num       (div_num),
    .div_den       (div_den),
    .ptr           (ptr),
    .stored        (stored),
    .value         (value),
    .cal_count     (cal_count)
  );

  asoc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // mux code of the slot the pointer holds after the item
  assign next_mux = mux_codes_r[ptr*5 +: 5];
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (seq_done) begin
        fin_r <= 1'b1;
      end else if (fin_r && out_free) begin
        fin_r <= 1'b0;
      end
      if (fin_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_r && out_free) begin
      out_data_r <= {cal_count, value, stored, next_mux};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // kind of the transaction in flight, checked against divider activity
  logic kind_is_update;
  assign kind_is_update = (kind_r == asoc_pkg::KIND_UPDATE);

  `ASOC_ASSERT_IMP(a_busy_blocks_input, clk, rst_n, seq_busy, !in_tready, "input taken while busy")
  `ASOC_ASSERT_NXT(a_accept_starts, clk, rst_n, in_acc, seq_busy, "accepted item did not start")
  `ASOC_ASSERT_IMP(a_div_in_update, clk, rst_n, div_busy, seq_busy && kind_is_update, "divider runs outside an update")
  `ASOC_ASSERT_NXT(a_done_stages, clk, rst_n, seq_done, fin_r && !seq_busy, "finished item not staged")

endmodule
